### src/histeq_pkg.sv
// Shared types and constants for the histogram equalizer.
// No dependencies; every other file except histeq_ram refers to it by scoped names.
package histeq_pkg;

    parameter int MAX_PIXELS = 1048576;

    localparam int PIX_W = 8;
    localparam int BINS = 1 << PIX_W;
    localparam int TOP_LEVEL = BINS - 1;
    localparam int CNT_W = $clog2(MAX_PIXELS + 1);
    localparam int NUM_W = CNT_W + PIX_W;
    localparam int Q_W = PIX_W;
    localparam int STEP_W = $clog2(Q_W);

    localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_PIXELS);

    localparam int OQ_DEPTH = 2;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    typedef enum logic
    {
        OP_COUNT = 1'b0,
        OP_MAP = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_RUN,
        ST_READ,
        ST_ACCUM,
        ST_DIVIDE
    } state_t;

endpackage

### src/histogram_equalizer_top.sv
// Top level of the two-pass 8-bit histogram equalizer.
// Depends on histeq_pkg, histeq_ram and histeq_div.
//
// Usage. Each request on the req channel carries opcode, pixel and last. A
// count request adds its pixel to the histogram and to the pixel total unless
// the total has reached MAX_PIXELS. A count request marked last then starts the
// table build: the bins are walked from 0 to 255, the running sum times 255 is
// divided by the total and the mapping table entry is written, and every bin and the
// total are cleared for the next image. A map request returns the table entry
// of its pixel on the res channel together with its last mark.
//
// Timing. Requests may be accepted in consecutive cycles while req_stall is low. A
// map result passes through the second stage register and the output queue
// before it is presented. The table build handles each bin in turn with one
// histogram RAM read, one accumulate and a bit-serial divide, and req_stall
// stays high during it. After reset a clearing pass writes zero to both RAMs,
// during which req_stall is high.
//
// Backpressure. Results pass through a two-entry output queue, so a stall on
// res holds the presented result stable and req_stall rises only when the
// queue could overflow, apart from the clearing pass and the table build.
module histogram_equalizer_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic                            opcode,
    input  logic [histeq_pkg::PIX_W-1:0]    pixel,
    input  logic                            last,
    output logic                            res_valid,
    input  logic                            res_stall,
    output logic [histeq_pkg::PIX_W-1:0]    equalized,
    output logic                            end_of_image
);

    histeq_pkg::state_t                     state_reg;
    histeq_pkg::state_t                     state_next;
    logic [histeq_pkg::PIX_W-1:0]           v_reg;
    logic [histeq_pkg::PIX_W-1:0]           v_next;
    logic [histeq_pkg::CNT_W-1:0]           cum_reg;
    logic [histeq_pkg::CNT_W-1:0]           cum_next;
    logic [histeq_pkg::CNT_W-1:0]           total_reg;
    logic [histeq_pkg::CNT_W-1:0]           total_next;

    // Second pipeline stage: the request whose RAM reads are now returning.
    logic                                   b_valid_reg;
    histeq_pkg::op_t                        b_op_reg;
    logic [histeq_pkg::PIX_W-1:0]           b_pixel_reg;
    logic                                   b_last_reg;

    // Forwarding of the previous cycle's histogram write.
    logic                                   fwd_valid_reg;
    logic [histeq_pkg::PIX_W-1:0]           fwd_addr_reg;
    logic [histeq_pkg::CNT_W-1:0]           fwd_data_reg;

    // Output queue.
    logic [histeq_pkg::PIX_W-1:0]           oq_eq_reg [histeq_pkg::OQ_DEPTH];
    logic                                   oq_eoi_reg [histeq_pkg::OQ_DEPTH];
    logic [histeq_pkg::OQ_PTR_W-1:0]        oq_wr_reg;
    logic [histeq_pkg::OQ_PTR_W-1:0]        oq_rd_reg;
    logic [histeq_pkg::OQ_CNT_W-1:0]        oq_cnt_reg;

    logic                                   hist_we;
    logic [histeq_pkg::PIX_W-1:0]           hist_waddr;
    logic [histeq_pkg::CNT_W-1:0]           hist_wdata;
    logic [histeq_pkg::PIX_W-1:0]           hist_raddr;
    logic [histeq_pkg::CNT_W-1:0]           hist_rdata;
    logic                                   lut_we;
    logic [histeq_pkg::PIX_W-1:0]           lut_wdata;
    logic [histeq_pkg::PIX_W-1:0]           lut_rdata;

    logic                                   req_accept;
    logic                                   res_accept;
    logic                                   push;
    logic                                   build_pend;
    logic                                   counted;
    logic [histeq_pkg::CNT_W-1:0]           cnt_cur;
    logic [histeq_pkg::CNT_W-1:0]           cum_sum;
    logic [histeq_pkg::NUM_W-1:0]           dividend;
    logic                                   div_start;
    logic                                   div_done;
    logic [histeq_pkg::Q_W-1:0]             quotient;

    assign req_accept = req_valid && !req_stall;
    assign res_valid = oq_cnt_reg != '0;
    assign res_accept = res_valid && !res_stall;
    assign equalized = oq_eq_reg[oq_rd_reg];
    assign end_of_image = oq_eoi_reg[oq_rd_reg];

    // A map request in the second stage lands in the output queue.
    assign push = b_valid_reg && (b_op_reg == histeq_pkg::OP_MAP);

    // A count request marked last sits in the second stage: the build follows.
    assign build_pend = b_valid_reg && (b_op_reg == histeq_pkg::OP_COUNT) && b_last_reg;

    // New requests are held off outside normal running, ahead of a build, and
    // whenever the queue might not have room for the result of a request accepted now.
    assign req_stall = (state_reg != histeq_pkg::ST_RUN) || build_pend ||
                       ({1'b0, oq_cnt_reg} + {{histeq_pkg::OQ_CNT_W{1'b0}}, push} >
                        {{histeq_pkg::OQ_CNT_W{1'b0}}, res_accept} + 1'b1);

    // The bin value read for this request is stale if the previous request
    // wrote the same bin in the cycle the read was issued.
    assign cnt_cur = (fwd_valid_reg && (fwd_addr_reg == b_pixel_reg)) ? fwd_data_reg
                                                                       : hist_rdata;
    assign counted = (state_reg == histeq_pkg::ST_RUN) && b_valid_reg &&
                     (b_op_reg == histeq_pkg::OP_COUNT) &&
                     (total_reg < histeq_pkg::MAX_COUNT);

    // Running sum including the bin just read, and that sum times 255.
    assign cum_sum = cum_reg + hist_rdata;
    assign dividend = ({{histeq_pkg::PIX_W{1'b0}}, cum_sum} << histeq_pkg::PIX_W) -
                      {{histeq_pkg::PIX_W{1'b0}}, cum_sum};

    always_comb
    begin
        state_next = state_reg;
        v_next = v_reg;
        cum_next = cum_reg;
        total_next = total_reg;
        hist_we = 1'b0;
        hist_waddr = b_pixel_reg;
        hist_wdata = cnt_cur + 1'b1;
        hist_raddr = pixel;
        lut_we = 1'b0;
        lut_wdata = '0;
        div_start = 1'b0;
        case (state_reg)
            histeq_pkg::ST_CLEAR:
            begin
                hist_we = 1'b1;
                hist_waddr = v_reg;
                hist_wdata = '0;
                lut_we = 1'b1;
                v_next = v_reg + 1'b1;
                if (v_reg == histeq_pkg::PIX_W'(histeq_pkg::TOP_LEVEL))
                begin
                    state_next = histeq_pkg::ST_RUN;
                end
            end
            histeq_pkg::ST_RUN:
            begin
                if (counted)
                begin
                    hist_we = 1'b1;
                    total_next = total_reg + 1'b1;
                end
                if (build_pend)
                begin
                    state_next = histeq_pkg::ST_READ;
                end
            end
            histeq_pkg::ST_READ:
            begin
                hist_raddr = v_reg;
                state_next = histeq_pkg::ST_ACCUM;
            end
            histeq_pkg::ST_ACCUM:
            begin
                cum_next = cum_sum;
                hist_we = 1'b1;
                hist_waddr = v_reg;
                hist_wdata = '0;
                div_start = 1'b1;
                state_next = histeq_pkg::ST_DIVIDE;
            end
            histeq_pkg::ST_DIVIDE:
            begin
                if (div_done)
                begin
                    lut_we = 1'b1;
                    lut_wdata = (total_reg == '0) ? '0 : quotient;
                    v_next = v_reg + 1'b1;
                    if (v_reg == histeq_pkg::PIX_W'(histeq_pkg::TOP_LEVEL))
                    begin
                        total_next = '0;
                        cum_next = '0;
                        state_next = histeq_pkg::ST_RUN;
                    end
                    else
                    begin
                        state_next = histeq_pkg::ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = histeq_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= histeq_pkg::ST_CLEAR;
            v_reg <= '0;
            cum_reg <= '0;
            total_reg <= '0;
            b_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
            oq_wr_reg <= '0;
            oq_rd_reg <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            v_reg <= v_next;
            cum_reg <= cum_next;
            total_reg <= total_next;
            b_valid_reg <= req_accept;
            fwd_valid_reg <= counted;
            if (push)
            begin
                oq_wr_reg <= oq_wr_reg + 1'b1;
            end
            if (res_accept)
            begin
                oq_rd_reg <= oq_rd_reg + 1'b1;
            end
            oq_cnt_reg <= oq_cnt_reg + {{(histeq_pkg::OQ_CNT_W - 1){1'b0}}, push}
                          - {{(histeq_pkg::OQ_CNT_W - 1){1'b0}}, res_accept};
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            b_op_reg <= histeq_pkg::op_t'(opcode);
            b_pixel_reg <= pixel;
            b_last_reg <= last;
        end
        fwd_addr_reg <= b_pixel_reg;
        fwd_data_reg <= hist_wdata;
        if (push)
        begin
            oq_eq_reg[oq_wr_reg] <= lut_rdata;
            oq_eoi_reg[oq_wr_reg] <= b_last_reg;
        end
    end

    histeq_ram #(
        .WIDTH(histeq_pkg::CNT_W),
        .DEPTH(histeq_pkg::BINS)
    ) u_hist_ram (
        .clk(clk),
        .we(hist_we),
        .waddr(hist_waddr),
        .wdata(hist_wdata),
        .raddr(hist_raddr),
        .rdata(hist_rdata)
    );

    histeq_ram #(
        .WIDTH(histeq_pkg::PIX_W),
        .DEPTH(histeq_pkg::BINS)
    ) u_lut_ram (
        .clk(clk),
        .we(lut_we),
        .waddr(v_reg),
        .wdata(lut_wdata),
        .raddr(pixel),
        .rdata(lut_rdata)
    );

    histeq_div u_div (
        .clk(clk),
        .rst_n(rst_n),
        .start(div_start),
        .dividend(dividend),
        .divisor(total_reg),
        .done(div_done),
        .quotient(quotient)
    );

endmodule

### src/histeq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; used for the histogram bins and the mapping table.
module histeq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/histeq_div.sv
// Restoring divider that yields one quotient bit per cycle.
// Depends on histeq_pkg; the quotient is known to fit in Q_W bits.
module histeq_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [histeq_pkg::NUM_W-1:0]        dividend,
    input  logic [histeq_pkg::CNT_W-1:0]        divisor,
    output logic                                done,
    output logic [histeq_pkg::Q_W-1:0]          quotient
);

    logic                               busy_reg;
    logic                               done_reg;
    logic [histeq_pkg::STEP_W-1:0]      step_reg;
    logic [histeq_pkg::NUM_W-1:0]       rem_reg;
    logic [histeq_pkg::NUM_W-1:0]       ds_reg;
    logic [histeq_pkg::Q_W-1:0]         q_reg;
    logic                               fits;

    assign fits = rem_reg >= ds_reg;
    assign done = done_reg;
    assign quotient = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == histeq_pkg::STEP_W'(histeq_pkg::Q_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            ds_reg <= {{(histeq_pkg::NUM_W - histeq_pkg::CNT_W){1'b0}}, divisor}
                      << (histeq_pkg::Q_W - 1);
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - ds_reg;
            end
            ds_reg <= ds_reg >> 1;
            q_reg <= {q_reg[histeq_pkg::Q_W-2:0], fits};
        end
    end

endmodule

### src/histeq_checker.sv
// Port-level checker for the histogram equalizer, bound to the top level.
// Depends on histeq_pkg and histogram_equalizer_top.
module histeq_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    input  logic                            req_stall,
    input  logic                            opcode,
    input  logic                            last,
    input  logic                            res_valid,
    input  logic                            res_stall,
    input  logic [histeq_pkg::PIX_W-1:0]    equalized,
    input  logic                            end_of_image
);

    logic [2:0] pend_reg;
    logic       map_in;
    logic       res_out;

    assign map_in = req_valid && !req_stall && (opcode == histeq_pkg::OP_MAP);
    assign res_out = res_valid && !res_stall;

    // Map requests accepted whose results have not yet been taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + {2'b00, map_in} - {2'b00, res_out};
        end
    end

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(equalized) && $stable(end_of_image))
        else $error("result changed while stalled");

    a_res_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> pend_reg != 3'd0)
        else $error("result without an outstanding map request");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 3'd3)
        else $error("too many map requests in flight");

    a_build_stall: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (opcode == histeq_pkg::OP_COUNT) && last |=> req_stall)
        else $error("request accepted while table build is due");

endmodule

bind histogram_equalizer_top histeq_checker u_histeq_checker (
    .clk(clk),
    .rst_n(rst_n),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .opcode(opcode),
    .last(last),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .equalized(equalized),
    .end_of_image(end_of_image)
);
